[hdl/md5_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and step tables for the MD5 message digest block.
// Used by md5_step and md5_message_digest; depends on nothing else.
package md5_pkg;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h00000080;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
  } md5_out_t;

  // Working variables a, b, c, d of one compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_work_t;

  function automatic logic [31:0] step_const(input logic [5:0] idx);
    logic [31:0] k;
    begin
      case (idx)
        6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    logic [4:0] s;
    begin
      case ({idx[5:4], idx[1:0]})
        4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
        4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
        4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
        4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

  // Message word index used by a step; all arithmetic is modulo 16.
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] i;
    logic [3:0] g;
    begin
      i = idx[3:0];
      case (idx[5:4])
        2'd0:    g = i;
        2'd1:    g = 4'((i << 2) + i + 4'd1);
        2'd2:    g = 4'((i << 1) + i + 4'd5);
        2'd3:    g = 4'((i << 3) - i);
        default: g = i;
      endcase
      return g;
    end
  endfunction

endpackage

[hdl/md5_message_digest.sv]
`timescale 1ns / 1ps
// MD5 message digest top level: block buffer, padding sequencer and digest output.
// Depends on md5_pkg and md5_step.
//
// Usage: the input channel takes one request per message word (in_req_i), with
// the first byte in bits 7:0. Only the request flagged end_of_message may carry
// fewer than four valid bytes, down to zero. A word that fills the 16-word buffer
// starts a compression that runs one MD5 step per cycle through a single shared
// step unit: 64 steps, then a fold of the result into the chaining value.
// While the compression, the padding or the digest output run, in_stall_o is high.
// A word that does not complete a block is taken without a stall; the sixteenth
// word of a block holds the input off through the compression and the fold.
// After the final request the block writes pad and length words at one per
// cycle while no compression runs, with one or two more compressions, then
// presents the digest words A, B, C, D on the output channel; last_word marks D.
// A high out_stall_i simply holds the current digest word. After D is taken the
// chaining value returns to the standard initial value and the byte count to
// zero. Reset does the same and leaves the block ready for a new message.
module md5_message_digest (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  md5_pkg::md5_in_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output md5_pkg::md5_out_t  out_req_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_FIN,
    S_PAD,
    S_OUT
  } state_e;

  state_e             state_q;
  logic [31:0]        cv_q [4];
  md5_pkg::md5_work_t work_q;
  md5_pkg::md5_work_t work_next;
  logic [5:0]         step_q;
  logic [63:0]        byte_count_q;
  logic [3:0]         fill_q;
  logic               pad_pend_q;
  logic               len_hi_q;
  logic               final_q;
  logic               done_q;
  logic [1:0]         out_idx_q;
  logic [31:0]        buf_q [16];

  logic [2:0]  nbytes;
  logic [63:0] count_add;
  logic [31:0] last_word_val;
  logic [31:0] pad_word;
  logic [31:0] push_word;
  logic        push_en;
  logic [63:0] bit_len;
  logic [31:0] step_msg;

  md5_step u_step (
    .work_i (work_q),
    .msg_i  (step_msg),
    .step_i (step_q),
    .work_o (work_next)
  );

  assign step_msg = buf_q[md5_pkg::msg_index(step_q)];
  assign bit_len  = {byte_count_q[60:0], 3'b000};

  always_comb begin
    nbytes = (in_req_i.valid_bytes > md5_pkg::FULL_BYTES) ? md5_pkg::FULL_BYTES
                                                          : in_req_i.valid_bytes;
    count_add = in_req_i.end_of_message ? {61'd0, nbytes} : 64'd4;
    // Final partial word keeps its valid bytes and puts the pad byte right after.
    case (nbytes)
      3'd0:    last_word_val = md5_pkg::PAD_WORD;
      3'd1:    last_word_val = {16'h0, md5_pkg::PAD_BYTE, in_req_i.message_word[7:0]};
      3'd2:    last_word_val = {8'h0, md5_pkg::PAD_BYTE, in_req_i.message_word[15:0]};
      3'd3:    last_word_val = {md5_pkg::PAD_BYTE, in_req_i.message_word[23:0]};
      default: last_word_val = in_req_i.message_word;
    endcase
    if (pad_pend_q) begin
      pad_word = md5_pkg::PAD_WORD;
    end else if (len_hi_q) begin
      pad_word = bit_len[63:32];
    end else if (fill_q == 4'd14) begin
      pad_word = bit_len[31:0];
    end else begin
      pad_word = 32'h0;
    end
    push_en   = 1'b0;
    push_word = pad_word;
    case (state_q)
      S_IDLE: begin
        push_en   = in_valid_i;
        push_word = in_req_i.end_of_message ? last_word_val : in_req_i.message_word;
      end
      S_PAD: begin
        push_en = 1'b1;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = (state_q == S_OUT);
  assign out_req_o.digest_word = cv_q[out_idx_q];
  assign out_req_o.word_number = out_idx_q;
  assign out_req_o.last_word   = (out_idx_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      buf_q[fill_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cv_q[0]      <= md5_pkg::IV_A;
      cv_q[1]      <= md5_pkg::IV_B;
      cv_q[2]      <= md5_pkg::IV_C;
      cv_q[3]      <= md5_pkg::IV_D;
      work_q       <= '0;
      step_q       <= '0;
      byte_count_q <= '0;
      fill_q       <= '0;
      pad_pend_q   <= 1'b0;
      len_hi_q     <= 1'b0;
      final_q      <= 1'b0;
      done_q       <= 1'b0;
      out_idx_q    <= '0;
    end else begin
      if (push_en) begin
        fill_q <= fill_q + 4'd1;
        if (fill_q == 4'd15) begin
          state_q  <= S_COMP;
          step_q   <= '0;
          work_q.a <= cv_q[0];
          work_q.b <= cv_q[1];
          work_q.c <= cv_q[2];
          work_q.d <= cv_q[3];
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            byte_count_q <= byte_count_q + count_add;
            if (in_req_i.end_of_message) begin
              final_q    <= 1'b1;
              pad_pend_q <= (nbytes == md5_pkg::FULL_BYTES);
              if (fill_q != 4'd15) begin
                state_q <= S_PAD;
              end
            end
          end
        end
        S_COMP: begin
          work_q <= work_next;
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          cv_q[0] <= cv_q[0] + work_q.a;
          cv_q[1] <= cv_q[1] + work_q.b;
          cv_q[2] <= cv_q[2] + work_q.c;
          cv_q[3] <= cv_q[3] + work_q.d;
          if (done_q) begin
            state_q <= S_OUT;
          end else if (final_q) begin
            state_q <= S_PAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_PAD: begin
          // Pad word first if still pending, then zeros up to slot 14, then the two length words.
          if (pad_pend_q) begin
            pad_pend_q <= 1'b0;
          end else if (len_hi_q) begin
            done_q <= 1'b1;
          end else if (fill_q == 4'd14) begin
            len_hi_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_idx_q <= out_idx_q + 2'd1;
            if (out_idx_q == 2'd3) begin
              cv_q[0]      <= md5_pkg::IV_A;
              cv_q[1]      <= md5_pkg::IV_B;
              cv_q[2]      <= md5_pkg::IV_C;
              cv_q[3]      <= md5_pkg::IV_D;
              byte_count_q <= '0;
              final_q      <= 1'b0;
              done_q       <= 1'b0;
              len_hi_q     <= 1'b0;
              state_q      <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The digest is only shown once the buffer has been fully consumed.
  a_out_buffer_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q == 4'd0 && done_q))
    else $error("digest presented with words left in the buffer");

  // The sixteenth accepted word starts a compression at once.
  a_full_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && fill_q == 4'd15) |=> (state_q == S_COMP && step_q == 6'd0))
    else $error("full block did not start a compression");

  // A compression always runs exactly 64 steps before the fold.
  a_comp_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && step_q == 6'd63) |=> (state_q == S_FIN))
    else $error("compression did not end after 64 steps");

  // Taking the last digest word restores the initial A word, the byte count and idle.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_req_o.last_word)
      |=> (cv_q[0] == md5_pkg::IV_A && byte_count_q == 64'd0 && state_q == S_IDLE))
    else $error("block did not restart after the digest");
`endif

endmodule

[hdl/md5_step.sv]
`timescale 1ns / 1ps
// One MD5 step: round function, four-term sum, rotate and add.
// Depends on md5_pkg for the working-variable type and the step tables.
module md5_step (
  input  md5_pkg::md5_work_t work_i,
  input  logic [31:0]        msg_i,
  input  logic [5:0]         step_i,
  output md5_pkg::md5_work_t work_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [4:0]  shamt;

  always_comb begin
    case (step_i[5:4])
      2'd0:    f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      2'd1:    f = (work_i.b & work_i.d) | (work_i.c & ~work_i.d);
      2'd2:    f = work_i.b ^ work_i.c ^ work_i.d;
      2'd3:    f = work_i.c ^ (work_i.b | ~work_i.d);
      default: f = 32'h0;
    endcase
  end

  assign shamt    = md5_pkg::rot_amount(step_i);
  assign sum      = work_i.a + f + md5_pkg::step_const(step_i) + msg_i;
  // Rotating left is the upper half of the doubled word shifted left.
  assign rot_wide = {sum, sum} << shamt;

  always_comb begin
    work_o.a = work_i.d;
    work_o.d = work_i.c;
    work_o.c = work_i.b;
    work_o.b = work_i.b + rot_wide[63:32];
  end

endmodule
